// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file ruu_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/ruu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RDM UID to UUID v3 block: MD5 constants and round helpers.
// No dependencies.
package ruu_pkg;
    localparam int unsigned Rounds = 64;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } chain_t;

    localparam word_t IV_A = 32'h67452301;
    localparam word_t IV_B = 32'hefcdab89;
    localparam word_t IV_C = 32'h98badcfe;
    localparam word_t IV_D = 32'h10325476;

    localparam logic [127:0] NS_UUID = 128'hba8afd463578463ca5a7a28ce3d32fe4;
    localparam logic [95:0] NAME_PREFIX = 96'h52444d204465766963652c20;

    function automatic word_t sine_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word index used by round i.
    function automatic logic [3:0] word_idx(input logic [5:0] i);
        logic [7:0] g;
        case (i[5:4])
            2'd0: g = {2'b00, i};
            2'd1: g = 8'(5 * i + 1);
            2'd2: g = 8'(3 * i + 5);
            default: g = 8'(7 * i);
        endcase
        return g[3:0];
    endfunction

    function automatic word_t bswap(input word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction
endpackage

// ===== hdl/ruu_round.sv =====
`timescale 1ns / 1ps
// One registered MD5 round with its own stall-aware valid bit.
// Depends on ruu_pkg.
module ruu_round #(
    parameter int unsigned ROUND = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [47:0]       in_uid,
    input  ruu_pkg::chain_t   in_chain,
    output logic              out_valid,
    output logic [47:0]       out_uid,
    output ruu_pkg::chain_t   out_chain
);
    localparam logic [5:0] RI = 6'(ROUND);
    localparam logic [3:0] G = ruu_pkg::word_idx(RI);
    localparam ruu_pkg::word_t K = ruu_pkg::sine_k(RI);
    localparam logic [4:0] S = ruu_pkg::rot_amt(RI);

    logic [511:0] blk;
    ruu_pkg::word_t w, f, sum, rot;
    logic [63:0] rot2;
    ruu_pkg::chain_t chain_next;

    logic out_valid_reg;
    logic [47:0] uid_reg;
    ruu_pkg::chain_t chain_reg;

    always_comb
    begin
        // block bytes 0..63 live in blk[511:0], byte 0 at the top
        blk = {ruu_pkg::NS_UUID, ruu_pkg::NAME_PREFIX, in_uid, 8'h80, 168'd0,
               64'h1001000000000000};
        w = ruu_pkg::bswap(blk[511 - 32 * G -: 32]);
        case (RI[5:4])
            2'd0: f = (in_chain.b & in_chain.c) | (~in_chain.b & in_chain.d);
            2'd1: f = (in_chain.b & in_chain.d) | (in_chain.c & ~in_chain.d);
            2'd2: f = in_chain.b ^ in_chain.c ^ in_chain.d;
            default: f = in_chain.c ^ (in_chain.b | ~in_chain.d);
        endcase
        sum = in_chain.a + f + K + w;
        rot2 = {sum, sum} << S;
        rot = rot2[63:32];
        chain_next.a = in_chain.d;
        chain_next.b = in_chain.b + rot;
        chain_next.c = in_chain.b;
        chain_next.d = in_chain.c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uid_reg <= in_uid;
            chain_reg <= chain_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_uid = uid_reg;
    assign out_chain = chain_reg;
endmodule

// ===== hdl/ruu_final.sv =====
`timescale 1ns / 1ps
// Final feed-forward, byte ordering and version/variant marking, registered.
// Depends on ruu_pkg.
module ruu_final (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  ruu_pkg::chain_t in_chain,
    output logic            out_valid,
    output logic [127:0]    out_uuid
);
    logic [127:0] dg;
    logic out_valid_reg;
    logic [127:0] uuid_reg;

    always_comb
    begin
        dg = {ruu_pkg::bswap(in_chain.a + ruu_pkg::IV_A), ruu_pkg::bswap(in_chain.b + ruu_pkg::IV_B),
              ruu_pkg::bswap(in_chain.c + ruu_pkg::IV_C), ruu_pkg::bswap(in_chain.d + ruu_pkg::IV_D)};
        // byte 6 version nibble, byte 8 variant bits
        dg[127 - 48 -: 8] = 8'h30 | (dg[127 - 48 -: 8] & 8'h0f);
        dg[127 - 64 -: 8] = 8'h80 | (dg[127 - 64 -: 8] & 8'h3f);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uuid_reg <= dg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_uuid = uuid_reg;
endmodule

// ===== hdl/rdm_uid_to_uuid_v3.sv =====
`timescale 1ns / 1ps
// Top level: RDM UID to version 3 UUID, a 65-stage MD5 pipeline.
// Depends on ruu_pkg, ruu_round and ruu_final.
//
// Usage:
//   s_axis carries one request per accepted beat: a 48-bit RDM UID in tdata.
//   m_axis returns the UUID: uuid_high in tdata[63:0], uuid_low in [127:64].
//   Each request runs through 64 round stages (one MD5 round each) and one
//   finishing stage that adds the chaining values and marks version/variant.
// Path: a request is loaded into the first of the 65 register stages when
//   accepted and reaches m_axis from the last; a stall holds it in place.
// Throughput: one request per cycle unless stalled; round adders set the clock.
// Stall: the whole pipeline advances only when the last stage is empty or
//   being taken, so a stalled result holds and nothing is lost or repeated;
//   s_axis_tready then follows m_axis_tready (bubbles in flight hold too).
// Reset: rst_n clears all valid bits; payload registers are not reset.
//   There is no state beyond the pipeline itself.
module rdm_uid_to_uuid_v3 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // [47:0] rdm_uid
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] uuid_high, [127:64] uuid_low
);
    localparam int unsigned N = ruu_pkg::Rounds;

    logic            v [0:N];
    logic [47:0]     uid [0:N];
    ruu_pkg::chain_t ch [0:N];
    logic            adv;
    logic [127:0]    uuid;

    // Advance everything when the output slot is free or being drained.
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    assign v[0] = s_axis_tvalid;
    assign uid[0] = s_axis_tdata;
    assign ch[0] = '{a: ruu_pkg::IV_A, b: ruu_pkg::IV_B, c: ruu_pkg::IV_C, d: ruu_pkg::IV_D};

    for (genvar r = 0; r < N; r++)
    begin : g_round
        ruu_round #(.ROUND(r)) u_round (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .in_valid(v[r]), .in_uid(uid[r]), .in_chain(ch[r]),
            .out_valid(v[r + 1]), .out_uid(uid[r + 1]), .out_chain(ch[r + 1])
        );
    end

    ruu_final u_final (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(v[N]), .in_chain(ch[N]),
        .out_valid(m_axis_tvalid), .out_uuid(uuid)
    );

    // uuid holds bytes 0..15 from the top; uuid_high is bytes 0..7.
    assign m_axis_tdata = {uuid[63:0], uuid[127:64]};
endmodule

// ===== hdl/ruu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for rdm_uid_to_uuid_v3, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ruu_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_IMPL(a_ready_free, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `ASSERT_IMPL(a_version, clk, rst_n, m_axis_tvalid, m_axis_tdata[15:12] == 4'h3)
    `ASSERT_IMPL(a_variant, clk, rst_n, m_axis_tvalid, m_axis_tdata[127:126] == 2'b10)
endmodule

bind rdm_uid_to_uuid_v3 ruu_checker u_ruu_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
